@@ hw/rtl/isa_pkg.sv @@
package isa_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ERR_W    = 32;
    localparam int SLOT_W   = 32;
    localparam int OUT_W    = 136;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_M1  = CNT_W'(CAPACITY - 1);
    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NONE    = 2'd3
    } isa_op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_RANGE     = 2'd2,
        STAT_DOUBLE    = 2'd3
    } isa_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } isa_state_t;

    typedef struct packed {
        logic load_in;
        logic rd_en;
        logic exec;
    } isa_cmd_t;

    typedef struct packed {
        logic out_free;
    } isa_sts_t;

endpackage

@@ hw/rtl/isa_ctrl.sv @@
module isa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  isa_pkg::isa_sts_t sts,
    output isa_pkg::isa_cmd_t cmd
);
    import isa_pkg::*;

    isa_state_t state_reg;
    isa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
            end
            S_EXEC: begin
                cmd.exec = sts.out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/isa_datapath.sv @@
module isa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  isa_pkg::isa_cmd_t             cmd,
    output isa_pkg::isa_sts_t             sts,
    input  logic [1:0]                    in_op,
    input  logic [isa_pkg::SLOT_W-1:0]    in_slot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_status,
    output logic [isa_pkg::OUT_W-1:0]     out_data
);
    import isa_pkg::*;

    // free stack and occupancy map, both without reset
    logic [IDX_W-1:0] stack_mem [CAPACITY];
    logic             map_mem   [CAPACITY];
    logic [IDX_W-1:0] stack_rd_reg;
    logic             map_rd_reg;

    logic [1:0]        op_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [CNT_W-1:0] depth_reg, depth_next;
    // lowest depth ever reached: stack entries below it have never been written
    logic [CNT_W-1:0] low_reg, low_next;
    logic [CNT_W-1:0] in_use_reg, in_use_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic [ERR_W-1:0] fail_reg, fail_next;
    logic [ERR_W-1:0] range_reg, range_next;
    logic [ERR_W-1:0] dbl_reg, dbl_next;
    logic             valid_reg, valid_next;

    logic [1:0]       status_reg, status_next;
    logic [IDX_W-1:0] grant_reg, grant_next;
    logic             occ_reg, occ_next;

    logic [CNT_W-1:0] top_pos;
    logic [IDX_W-1:0] pop_slot;
    logic [IDX_W-1:0] slot_idx;
    logic             in_range;
    logic             map_bit;
    logic             stack_we;
    logic             map_we;
    logic [IDX_W-1:0] map_waddr;
    logic             map_wdata;

    assign sts.out_free = !valid_reg || out_ready;

    assign top_pos  = depth_reg - CNT_W'(1);
    assign pop_slot = (top_pos < low_reg) ? IDX_W'(CAP_M1 - top_pos) : stack_rd_reg;
    assign slot_idx = slot_reg[IDX_W-1:0];
    assign in_range = slot_reg < SLOT_W'(CAPACITY);
    // a slot never handed out since reset reads as free
    assign map_bit  = map_rd_reg && ((CAP_M1 - {1'b0, slot_idx}) >= low_reg);

    always_comb begin
        depth_next  = depth_reg;
        low_next    = low_reg;
        in_use_next = in_use_reg;
        peak_next   = peak_reg;
        fail_next   = fail_reg;
        range_next  = range_reg;
        dbl_next    = dbl_reg;
        status_next = STAT_OK;
        grant_next  = '0;
        occ_next    = 1'b0;
        stack_we    = 1'b0;
        map_we      = 1'b0;
        map_waddr   = slot_idx;
        map_wdata   = 1'b0;
        case (isa_op_t'(op_reg))
            OP_ALLOC: begin
                if (depth_reg == '0 || depth_reg > CAP_CNT) begin
                    status_next = STAT_EXHAUSTED;
                    if (fail_reg != ERR_MAX) begin
                        fail_next = fail_reg + ERR_W'(1);
                    end
                end else begin
                    depth_next  = top_pos;
                    if (top_pos < low_reg) begin
                        low_next = top_pos;
                    end
                    grant_next  = pop_slot;
                    map_we      = 1'b1;
                    map_waddr   = pop_slot;
                    map_wdata   = 1'b1;
                    in_use_next = in_use_reg + CNT_W'(1);
                    if (in_use_next > peak_reg) begin
                        peak_next = in_use_next;
                    end
                end
            end
            OP_RELEASE: begin
                if (!in_range) begin
                    status_next = STAT_RANGE;
                    if (range_reg != ERR_MAX) begin
                        range_next = range_reg + ERR_W'(1);
                    end
                end else if (!map_bit) begin
                    status_next = STAT_DOUBLE;
                    if (dbl_reg != ERR_MAX) begin
                        dbl_next = dbl_reg + ERR_W'(1);
                    end
                end else begin
                    map_we = 1'b1;
                    if (depth_reg < CAP_CNT) begin
                        stack_we   = 1'b1;
                        depth_next = depth_reg + CNT_W'(1);
                    end
                    if (in_use_reg != '0) begin
                        in_use_next = in_use_reg - CNT_W'(1);
                    end
                end
            end
            OP_QUERY: begin
                occ_next = in_range && map_bit;
            end
            default: begin
                status_next = STAT_OK;
            end
        endcase
    end

    assign valid_next = cmd.exec || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= CAP_CNT;
            low_reg    <= CAP_CNT;
            in_use_reg <= '0;
            peak_reg   <= '0;
            fail_reg   <= '0;
            range_reg  <= '0;
            dbl_reg    <= '0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmd.exec) begin
                depth_reg  <= depth_next;
                low_reg    <= low_next;
                in_use_reg <= in_use_next;
                peak_reg   <= peak_next;
                fail_reg   <= fail_next;
                range_reg  <= range_next;
                dbl_reg    <= dbl_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= in_op;
            slot_reg <= in_slot;
        end
        if (cmd.exec) begin
            status_reg <= status_next;
            grant_reg  <= grant_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            stack_rd_reg <= stack_mem[top_pos[IDX_W-1:0]];
            map_rd_reg   <= map_mem[slot_idx];
        end
        if (cmd.exec && stack_we) begin
            stack_mem[depth_reg[IDX_W-1:0]] <= slot_idx;
        end
        if (cmd.exec && map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
    end

    // results reflect the counters after the step, so read the updated registers
    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_data   = {7'd0, dbl_reg, range_reg, fail_reg, peak_reg, in_use_reg,
                         occ_reg, grant_reg};

endmodule

@@ hw/rtl/index_slot_allocator.sv @@
// Slot index allocator for a pool of 1024 slots. Each request item (s_tuser opcode:
// allocate, release, query; s_tdata slot index) yields one result item on the m_
// side. A free-list stack hands out indices last-released-first, starting at 0, and
// an occupancy map catches releases of free slots; both live in single-port style
// memories with registered reads, so every item passes three steps (accept, memory
// read, update and result); the update step waits while m_tready stalls the result.
// No clearing pass follows reset: a low-water mark of the stack tells which entries
// still hold their reset contents. Every result carries the in-use and peak counts
// and three saturating error counters, all as of after that item.
module index_slot_allocator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // slot_index
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // granted_index, occupied, entries_in_use,
                                    // peak_in_use, failed_allocations,
                                    // out_of_range_releases, repeated_releases, zero pad
    output logic [1:0]   m_tuser    // status
);
    import isa_pkg::*;

    isa_cmd_t cmd;
    isa_sts_t sts;

    isa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    isa_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_slot    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

@@ hw/rtl/isa_checker.sv @@
module isa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic [1:0]   m_tuser
);
    import isa_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time: the input closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[32:22] >= m_tdata[21:11] && m_tdata[21:11] <= CAP_CNT)
        else $error("in-use count above peak or capacity");

    a_fail_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[10:0] == 11'd0)
        else $error("grant or occupied flag on failed item");

    // a refused allocate can only happen with every slot in use
    a_exhaust: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_EXHAUSTED |-> m_tdata[21:11] == CAP_CNT)
        else $error("pool reported empty with free slots");

endmodule

bind index_slot_allocator isa_checker u_isa_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import isa_pkg::*;

    typedef struct packed {
        isa_op_t     op;
        logic [31:0] idx;
    } slot_request_t;

    typedef struct packed {
        isa_status_t      status;
        logic [IDX_W-1:0] granted;
        logic             occupied;
        logic [CNT_W-1:0] in_use;
        logic [CNT_W-1:0] peak;
        logic [ERR_W-1:0] failed_allocs;
        logic [ERR_W-1:0] range_releases;
        logic [ERR_W-1:0] repeat_releases;
    } slot_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;   // slot_index
    logic [1:0]   s_tuser = '0;   // opcode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;        // granted_index, occupied, entries_in_use, peak_in_use,
                                  // failed_allocations, out_of_range_releases,
                                  // repeated_releases, zero pad
    logic [1:0]   m_tuser;        // status

    index_slot_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // allocator state as the bench predicts it
    logic [IDX_W-1:0] free_lifo [CAPACITY];
    logic [CNT_W-1:0] lifo_depth;
    logic             slot_busy [CAPACITY];
    logic [CNT_W-1:0] n_use;
    logic [CNT_W-1:0] n_peak;
    logic [ERR_W-1:0] n_failed;
    logic [ERR_W-1:0] n_range;
    logic [ERR_W-1:0] n_repeat;

    slot_request_t requests_pending [$];
    slot_result_t  answers_due [$];

    int issued_n;
    int taken_n;
    int got_n;
    int fail_n;
    int gap_left;
    int ready_wait;
    int hold_left;
    bit hold_done;
    slot_request_t next_req;
    slot_result_t  seen;
    slot_result_t  want;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [ERR_W-1:0] sat_bump(input logic [ERR_W-1:0] c);
        return (c == ERR_MAX) ? c : c + 1'b1;
    endfunction

    function automatic void allocator_reset();
        for (int i = 0; i < CAPACITY; i++) begin
            free_lifo[i] = IDX_W'(CAPACITY - 1 - i);
            slot_busy[i] = 1'b0;
        end
        lifo_depth = CAP_CNT;
        n_use      = '0;
        n_peak     = '0;
        n_failed   = '0;
        n_range    = '0;
        n_repeat   = '0;
    endfunction

    function automatic slot_result_t allocator_step(isa_op_t op, logic [31:0] idx);
        slot_result_t r;
        logic         in_pool;
        r       = '0;
        in_pool = idx < CAPACITY;
        case (op)
            OP_ALLOC: begin
                if (lifo_depth == 0) begin
                    r.status = STAT_EXHAUSTED;
                    n_failed = sat_bump(n_failed);
                end else begin
                    lifo_depth = lifo_depth - 1'b1;
                    r.granted  = free_lifo[lifo_depth[IDX_W-1:0]];
                    slot_busy[r.granted] = 1'b1;
                    n_use = n_use + 1'b1;
                    if (n_use > n_peak)
                        n_peak = n_use;
                end
            end
            OP_RELEASE: begin
                if (!in_pool) begin
                    r.status = STAT_RANGE;
                    n_range  = sat_bump(n_range);
                end else if (!slot_busy[idx[IDX_W-1:0]]) begin
                    r.status = STAT_DOUBLE;
                    n_repeat = sat_bump(n_repeat);
                end else begin
                    slot_busy[idx[IDX_W-1:0]] = 1'b0;
                    // a full stack cannot take a push; it would be dropped
                    if (lifo_depth < CAP_CNT) begin
                        free_lifo[lifo_depth[IDX_W-1:0]] = idx[IDX_W-1:0];
                        lifo_depth = lifo_depth + 1'b1;
                    end
                    if (n_use > 0)
                        n_use = n_use - 1'b1;
                end
            end
            OP_QUERY: begin
                r.occupied = in_pool && slot_busy[idx[IDX_W-1:0]];
            end
            default: ;
        endcase
        r.in_use          = n_use;
        r.peak            = n_peak;
        r.failed_allocs   = n_failed;
        r.range_releases  = n_range;
        r.repeat_releases = n_repeat;
        return r;
    endfunction

    // stretches of back-to-back items between randomly paced ones
    function automatic int draw_wait(int n);
        return ((n / 128) % 4 == 1) ? 0 : $urandom_range(0, 5);
    endfunction

    // a slot that is in use now, if any; otherwise a free one
    function automatic logic [31:0] busy_slot();
        int start;
        start = $urandom_range(0, CAPACITY - 1);
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_busy[(start + i) % CAPACITY])
                return (start + i) % CAPACITY;
        end
        return start;
    endfunction

    task automatic queue_request(isa_op_t op, logic [31:0] idx);
        slot_request_t r;
        while (requests_pending.size() >= 4)
            @(negedge aclk);
        r.op  = op;
        r.idx = idx;
        requests_pending.push_back(r);
        issued_n++;
    endtask

    task automatic print_result(string tag, slot_result_t r);
        $display("  %s: status=%0d grant=%0d occ=%0d use=%0d peak=%0d fail=%0d rng=%0d rep=%0d",
                 tag, r.status, r.granted, r.occupied, r.in_use, r.peak,
                 r.failed_allocs, r.range_releases, r.repeat_releases);
    endtask

    // sender: one item offered at a time, held until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                answers_due.push_back(allocator_step(isa_op_t'(s_tuser), s_tdata));
                taken_n++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (requests_pending.size() != 0) begin
                    next_req = requests_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.idx;
                    s_tuser  <= next_req.op;
                    gap_left = draw_wait(taken_n);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each result item, then stall a random number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_wait = 0;
            hold_left  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_n++;
                seen.status          = isa_status_t'(m_tuser);
                seen.granted         = m_tdata[9:0];
                seen.occupied        = m_tdata[10];
                seen.in_use          = m_tdata[21:11];
                seen.peak            = m_tdata[32:22];
                seen.failed_allocs   = m_tdata[64:33];
                seen.range_releases  = m_tdata[96:65];
                seen.repeat_releases = m_tdata[128:97];
                if (answers_due.size() == 0) begin
                    if (fail_n < 10) begin
                        $display("unexpected result item %0d", got_n);
                        print_result("actual", seen);
                    end
                    fail_n++;
                end else begin
                    want = answers_due.pop_front();
                    if (seen.status !== want.status || seen.granted !== want.granted
                            || seen.occupied !== want.occupied || seen.in_use !== want.in_use
                            || seen.peak !== want.peak
                            || seen.failed_allocs !== want.failed_allocs
                            || seen.range_releases !== want.range_releases
                            || seen.repeat_releases !== want.repeat_releases
                            || m_tdata[135:129] !== '0) begin
                        if (fail_n < 10) begin
                            $display("mismatch on result item %0d (pad=%h)",
                                     got_n, m_tdata[135:129]);
                            print_result("expected", want);
                            print_result("actual  ", seen);
                        end
                        fail_n++;
                    end
                end
            end
            // one long back-pressure stretch lets the block fill up and stall its input
            if (!hold_done && got_n >= 400) begin
                hold_done = 1'b1;
                hold_left = 300;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                ready_wait = draw_wait(got_n);
                m_tready <= (ready_wait == 0);
            end else if (ready_wait > 0) begin
                ready_wait--;
                m_tready <= (ready_wait == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        bit               filling;
        logic [ERR_W-1:0] exh_mark;
        int               pick;
        allocator_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opening: fresh pool, error paths, lifo reuse, unused opcode
        queue_request(OP_QUERY,   32'd0);
        queue_request(OP_RELEASE, 32'd0);
        queue_request(OP_ALLOC,   32'd0);
        queue_request(OP_ALLOC,   32'hFFFF_FFFF);
        queue_request(OP_ALLOC,   32'h5555_5555);
        queue_request(OP_QUERY,   32'd1);
        queue_request(OP_QUERY,   32'd1023);
        queue_request(OP_QUERY,   32'd1024);
        queue_request(OP_QUERY,   32'hFFFF_FFFF);
        queue_request(OP_RELEASE, 32'd1024);
        queue_request(OP_RELEASE, 32'hFFFF_FFFF);
        queue_request(OP_RELEASE, 32'h8000_0000);
        queue_request(OP_RELEASE, 32'd1);
        queue_request(OP_RELEASE, 32'd1);
        queue_request(OP_QUERY,   32'd1);
        queue_request(OP_ALLOC,   32'hAAAA_AAAA);
        queue_request(OP_NONE,    32'hFFFF_FFFF);
        queue_request(OP_NONE,    32'd0);
        queue_request(OP_RELEASE, 32'd1023);
        queue_request(OP_QUERY,   32'd2);
        queue_request(OP_RELEASE, 32'd2);
        queue_request(OP_ALLOC,   32'd0);

        // random part: fill the pool past exhaustion, then drain it, and so on
        filling  = 1'b1;
        exh_mark = n_failed;
        for (int k = 0; k < 2000; k++) begin
            @(negedge aclk);
            if (filling && n_failed >= exh_mark + 4) begin
                filling = 1'b0;
            end else if (!filling && n_use < 16) begin
                filling  = 1'b1;
                exh_mark = n_failed;
            end
            pick = $urandom_range(0, 99);
            if (pick < (filling ? 90 : 12))
                queue_request(OP_ALLOC, $urandom);
            else if (pick < (filling ? 94 : 82))
                queue_request(OP_RELEASE, busy_slot());
            else if (pick < (filling ? 97 : 92))
                queue_request(OP_QUERY, $urandom_range(0, 1) ? busy_slot()
                                                            : $urandom_range(0, CAPACITY - 1));
            else begin
                case ($urandom_range(0, 3))
                    0: queue_request(OP_NONE, $urandom);
                    1: queue_request(OP_RELEASE, $urandom);
                    2: queue_request(OP_QUERY, $urandom);
                    default: queue_request(OP_RELEASE, $urandom_range(0, CAPACITY - 1));
                endcase
            end
        end

        while (taken_n != issued_n || answers_due.size() != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_n == 0 && answers_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
